// ===== rtl/wnrh_pkg.sv =====
// Package with shared constants, codes and types of the noise RMS histogram block.
`default_nettype none
package wnrh_pkg;
    localparam int HIST_BINS = 163;
    localparam int FRAME_SAMPLES = 1024;
    localparam int BIN_W = 8;
    localparam int CNT_W = 11;
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int DVD_W = 61;
    localparam int DVS_W = 21;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] JOB_FRAME = 2'd0;
    localparam logic [1:0] JOB_READ = 2'd1;
    localparam logic [1:0] JOB_CLEAR = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRP_SEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHN_SEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_UPPER = 3'd5;

    typedef struct packed {
        logic [9:0]  win_start;
        logic [10:0] win_end;
        logic [4:0]  grp_sel;
        logic [4:0]  chn_sel;
        logic [11:0] amp_limit;
        logic [19:0] hist_upper;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] cnt;
        logic [21:0]      sum;
        logic [33:0]      sq;
        logic [11:0]      mn;
        logic [11:0]      mx;
        logic [BIN_W-1:0] bsel;
    } t_job;

    typedef struct packed {
        logic             kind;
        logic [19:0]      rms;
        logic [11:0]      amp;
        logic             quiet;
        logic [BIN_W-1:0] bin;
        logic [31:0]      count;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/wnrh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wnrh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 163
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/wnrh_jobq.sv =====
// Four-entry job queue between the sample front end and the arithmetic back end.
`default_nettype none
module wnrh_jobq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wnrh_pkg::t_job      i_job,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output wnrh_pkg::t_job      o_job
);
    wnrh_pkg::t_job r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic do_push, do_pop;

    assign o_full = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_job = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 2'd1;
            if (do_pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b0, do_push} - {2'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/wnrh_front.sv =====
// Front end: frame selection, per-sample window accumulation and job issue.
`default_nettype none
module wnrh_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  wire [1:0]           i_action,
    input  wire [11:0]          i_sample,
    input  wire [9:0]           i_sample_index,
    input  wire [3:0]           i_group,
    input  wire [3:0]           i_channel,
    input  wire                 i_last_sample,
    input  wire [7:0]           i_bin_select,
    input  wnrh_pkg::t_cfg      i_cfg,
    output logic                o_job_push,
    output wnrh_pkg::t_job      o_job,
    input  wire                 i_job_full
);
    localparam int CNT_W = wnrh_pkg::CNT_W;

    logic r_open, r_sel;
    logic [wnrh_pkg::CNT_W-1:0] r_cnt;
    logic [21:0] r_sum;
    logic [33:0] r_sq;
    logic [11:0] r_mn, r_mx;

    logic accept, sel0, inwin;
    logic [wnrh_pkg::CNT_W-1:0] cnt0, n_cnt;
    logic [21:0] sum0, n_sum;
    logic [33:0] sq0, n_sq;
    logic [11:0] mn0, mx0, n_mn, n_mx;
    logic [23:0] sample_sq;

    function automatic logic sel_match(input logic [4:0] sel, input logic [3:0] tag);
        logic m;
        if (sel == 5'h1F) m = 1'b1;
        else if (sel[4]) m = 1'b0;
        else m = (sel[3:0] == tag);
        return m;
    endfunction

    assign full = i_job_full;
    assign accept = push && !i_job_full;
    assign sample_sq = i_sample * i_sample;

    always_comb begin
        if (r_open) begin
            sel0 = r_sel;
            cnt0 = r_cnt;
            sum0 = r_sum;
            sq0 = r_sq;
            mn0 = r_mn;
            mx0 = r_mx;
        end else begin
            sel0 = sel_match(i_cfg.grp_sel, i_group) && sel_match(i_cfg.chn_sel, i_channel);
            cnt0 = '0;
            sum0 = '0;
            sq0 = '0;
            mn0 = 12'hFFF;
            mx0 = '0;
        end
        inwin = (i_sample_index >= i_cfg.win_start) && ({1'b0, i_sample_index} < i_cfg.win_end)
            && (cnt0 < CNT_W'(wnrh_pkg::FRAME_SAMPLES));
        n_cnt = cnt0;
        n_sum = sum0;
        n_sq = sq0;
        n_mn = mn0;
        n_mx = mx0;
        if (inwin) begin
            n_cnt = cnt0 + 1'b1;
            n_sum = sum0 + {10'b0, i_sample};
            n_sq = sq0 + {10'b0, sample_sq};
            if (i_sample < mn0) n_mn = i_sample;
            if (i_sample > mx0) n_mx = i_sample;
        end
        o_job.cnt = n_cnt;
        o_job.sum = n_sum;
        o_job.sq = n_sq;
        o_job.mn = n_mn;
        o_job.mx = n_mx;
        o_job.bsel = i_bin_select;
        o_job.kind = wnrh_pkg::JOB_FRAME;
        o_job_push = 1'b0;
        unique case (i_action)
            wnrh_pkg::ACT_SAMPLE: begin
                o_job_push = accept && i_last_sample && sel0;
            end
            wnrh_pkg::ACT_READ: begin
                o_job.kind = wnrh_pkg::JOB_READ;
                o_job_push = accept;
            end
            wnrh_pkg::ACT_CLEAR: begin
                o_job.kind = wnrh_pkg::JOB_CLEAR;
                o_job_push = accept;
            end
            default: o_job_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_action == wnrh_pkg::ACT_SAMPLE) begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
            r_sq <= n_sq;
            r_mn <= n_mn;
            r_mx <= n_mx;
        end
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_sel <= 1'b0;
        end else if (accept && i_action == wnrh_pkg::ACT_SAMPLE) begin
            r_open <= !i_last_sample;
            r_sel <= sel0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/wnrh_back.sv =====
// Back end: per-frame RMS arithmetic, histogram update, clear and readout, result queue.
`default_nettype none
module wnrh_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wnrh_pkg::t_cfg      i_cfg,
    input  wire                 i_job_empty,
    input  wnrh_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                empty,
    input  wire                 pop,
    output wnrh_pkg::t_res      o_res
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_NUM = 4'd3;
    localparam logic [3:0] S_DIV = 4'd4;
    localparam logic [3:0] S_SQINIT = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_CLASS = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_BIN = 4'd9;
    localparam logic [3:0] S_HRD = 4'd10;
    localparam logic [3:0] S_HWR = 4'd11;
    localparam logic [3:0] S_OUT = 4'd12;

    localparam int DVD_W = wnrh_pkg::DVD_W;
    localparam int DVS_W = wnrh_pkg::DVS_W;
    localparam int BIN_W = wnrh_pkg::BIN_W;
    localparam logic [BIN_W-1:0] BINS = BIN_W'(wnrh_pkg::HIST_BINS);

    logic [3:0] r_state;
    wnrh_pkg::t_job r_job;
    wnrh_pkg::t_res r_res;
    logic [44:0] r_acc;
    logic [43:0] r_ss;
    logic [DVS_W-1:0] r_nn;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [5:0] r_step;
    logic r_phase;
    logic [DVD_W-1:0] r_v, r_r, r_bit;
    logic [BIN_W-1:0] r_bin;
    logic [wnrh_pkg::HIST_BINS-1:0] r_valid;
    logic [31:0] r_ovf;

    wnrh_pkg::t_res r_ofifo [2];
    logic r_ow, r_or;
    logic [1:0] r_ocnt;
    logic ofull, opush, opop;

    logic [DVS_W:0] rem_sh;
    logic ge;
    logic [DVD_W-1:0] sq_sum;
    logic [11:0] amp;
    logic [BIN_W-1:0] rd_idx, ram_raddr;
    logic [31:0] ram_q, bin_val, cell_inc, read_cnt;
    logic ram_we;
    logic [27:0] mul_hi;
    logic [27:0] rms_scaled;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign ge = rem_sh >= {1'b0, r_dvs};
    assign sq_sum = r_r + r_bit;
    assign amp = r_job.mx - r_job.mn;
    assign rd_idx = (r_job.kind == wnrh_pkg::JOB_FRAME) ? r_bin : r_job.bsel;
    assign ram_raddr = (rd_idx < BINS) ? rd_idx : '0;
    assign bin_val = r_valid[ram_raddr] ? ram_q : 32'd0;
    assign cell_inc = (bin_val == 32'hFFFF_FFFF) ? bin_val : bin_val + 32'd1;
    assign ram_we = (r_state == S_HWR) && (r_job.kind == wnrh_pkg::JOB_FRAME);
    assign mul_hi = r_job.cnt * r_job.sq[33:17];
    assign rms_scaled = r_res.rms * BINS;
    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;

    always_comb begin
        if (r_job.bsel < BINS) read_cnt = bin_val;
        else if (r_job.bsel == BINS) read_cnt = r_ovf;
        else read_cnt = 32'd0;
    end

    wnrh_ram #(.WIDTH(32), .DEPTH(wnrh_pkg::HIST_BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bin),
        .i_wdata (cell_inc),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign ofull = r_ocnt[1];
    assign empty = (r_ocnt == 2'd0);
    assign o_res = r_ofifo[r_or];
    assign opush = (r_state == S_OUT) && !ofull;
    assign opop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (opush) r_ofifo[r_ow] <= r_res;
        if (!i_rst_n) begin
            r_ow <= 1'b0;
            r_or <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (opush) r_ow <= !r_ow;
            if (opop) r_or <= !r_or;
            r_ocnt <= r_ocnt + {1'b0, opush} - {1'b0, opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ovf <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job <= i_job;
                        r_res <= '0;
                        r_bin <= '0;
                        unique case (i_job.kind)
                            wnrh_pkg::JOB_CLEAR: begin
                                r_valid <= '0;
                                r_ovf <= '0;
                            end
                            wnrh_pkg::JOB_READ: begin
                                r_state <= S_HRD;
                            end
                            default: begin
                                r_state <= (i_job.cnt == '0) ? S_OUT : S_MUL1;
                            end
                        endcase
                    end
                end
                S_MUL1: begin
                    r_acc <= 45'(r_job.cnt * r_job.sq[16:0]);
                    r_ss <= r_job.sum * r_job.sum;
                    r_nn <= 21'(r_job.cnt * r_job.cnt);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc <= r_acc + {mul_hi, 17'b0};
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_dvd <= {r_acc - {1'b0, r_ss}, 16'b0};
                    r_dvs <= r_nn;
                    r_rem <= '0;
                    r_step <= 6'(DVD_W - 1);
                    r_phase <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : DVS_W'(rem_sh);
                    r_dvd <= {r_dvd[DVD_W-2:0], ge};
                    r_step <= r_step - 6'd1;
                    if (r_step == '0) r_state <= r_phase ? S_BIN : S_SQINIT;
                end
                S_SQINIT: begin
                    r_v <= r_dvd;
                    r_r <= '0;
                    r_bit <= {1'b1, {(DVD_W-1){1'b0}}};
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_v >= sq_sum) begin
                        r_v <= r_v - sq_sum;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_res.rms <= r_r[19:0];
                    r_res.amp <= amp;
                    if (amp < i_cfg.amp_limit) begin
                        r_res.quiet <= 1'b1;
                        if (i_cfg.hist_upper == '0) begin
                            r_dvd <= DVD_W'(BINS);
                            r_state <= S_BIN;
                        end else begin
                            r_state <= S_SCALE;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SCALE: begin
                    r_dvd <= DVD_W'(rms_scaled);
                    r_dvs <= {1'b0, i_cfg.hist_upper};
                    r_rem <= '0;
                    r_step <= 6'(DVD_W - 1);
                    r_phase <= 1'b1;
                    r_state <= S_DIV;
                end
                S_BIN: begin
                    if (r_dvd >= DVD_W'(BINS)) begin
                        r_res.bin <= BINS;
                        if (r_ovf != 32'hFFFF_FFFF) r_ovf <= r_ovf + 32'd1;
                        r_state <= S_OUT;
                    end else begin
                        r_bin <= r_dvd[BIN_W-1:0];
                        r_res.bin <= r_dvd[BIN_W-1:0];
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HWR;
                end
                S_HWR: begin
                    if (r_job.kind == wnrh_pkg::JOB_FRAME) begin
                        r_valid[r_bin] <= 1'b1;
                    end else begin
                        r_res.kind <= wnrh_pkg::KIND_READ;
                        r_res.bin <= r_job.bsel;
                        r_res.count <= read_cnt;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!ofull) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/windowed_noise_rms_histogram.sv =====
// Top level of the windowed baseline noise RMS histogram block.
//
// Input beats enter through push/full: a beat is taken at a clock edge with
// push high and full low. Sample beats are accumulated at one per cycle; a
// beat never waits on the arithmetic unless the four-entry job queue is full.
// Results leave through empty/pop: the oldest result is on the o_ ports while
// empty is low and is taken at an edge with pop high.
// A quiet frame result passes through the shared one-bit-per-cycle divider
// (variance, then bin scaling unless hist_upper is zero) and the 31-step square
// root; a frame that is not quiet skips the scaling and histogram update, and an
// empty window goes straight to the output. A clear empties the histogram and
// queues no result. Jobs run one at a time in arrival order.
// When the receiver stalls, up to two results wait in the output queue, one
// more in the back end, then four jobs in the job queue, after which full rises.
// Reset, synchronous and active low, loads the default register values,
// closes any open frame and empties the histogram at once through per-bin
// valid bits. Configuration is written through i_cfg_we, i_cfg_idx, i_cfg_data.
`default_nettype none
module windowed_noise_rms_histogram (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire [1:0]   i_action,
    input  wire [11:0]  i_sample,
    input  wire [9:0]   i_sample_index,
    input  wire [3:0]   i_group,
    input  wire [3:0]   i_channel,
    input  wire         i_last_sample,
    input  wire [7:0]   i_bin_select,
    output logic        empty,
    input  wire         pop,
    output logic        o_kind,
    output logic [19:0] o_rms_value,
    output logic [11:0] o_amplitude,
    output logic        o_quiet,
    output logic [7:0]  o_bin_number,
    output logic [31:0] o_bin_count,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [19:0]  i_cfg_data
);
    wnrh_pkg::t_cfg r_cfg;
    wnrh_pkg::t_job fr_job, q_job;
    wnrh_pkg::t_res res;
    logic job_push, job_full, job_empty, job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_start <= 10'd360;
            r_cfg.win_end <= 11'd900;
            r_cfg.grp_sel <= 5'h1F;
            r_cfg.chn_sel <= 5'h1F;
            r_cfg.amp_limit <= 12'd100;
            r_cfg.hist_upper <= 20'd5120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wnrh_pkg::CFG_WIN_START: r_cfg.win_start <= i_cfg_data[9:0];
                wnrh_pkg::CFG_WIN_END: r_cfg.win_end <= i_cfg_data[10:0];
                wnrh_pkg::CFG_GRP_SEL: r_cfg.grp_sel <= i_cfg_data[4:0];
                wnrh_pkg::CFG_CHN_SEL: r_cfg.chn_sel <= i_cfg_data[4:0];
                wnrh_pkg::CFG_AMP_LIMIT: r_cfg.amp_limit <= i_cfg_data[11:0];
                wnrh_pkg::CFG_HIST_UPPER: r_cfg.hist_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wnrh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_sample       (i_sample),
        .i_sample_index (i_sample_index),
        .i_group        (i_group),
        .i_channel      (i_channel),
        .i_last_sample  (i_last_sample),
        .i_bin_select   (i_bin_select),
        .i_cfg          (r_cfg),
        .o_job_push     (job_push),
        .o_job          (fr_job),
        .i_job_full     (job_full)
    );

    wnrh_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (fr_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (q_job)
    );

    wnrh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (q_job),
        .o_job_pop   (job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res)
    );

    assign o_kind = res.kind;
    assign o_rms_value = res.rms;
    assign o_amplitude = res.amp;
    assign o_quiet = res.quiet;
    assign o_bin_number = res.bin;
    assign o_bin_count = res.count;
endmodule
`default_nettype wire
